// ----- hdl/luc_pkg.sv -----
// Package for the Lucas binomial block: widths, state and phase codes,
// and response structs of the arithmetic units.
// No dependencies.
package luc_pkg;

    localparam int ARG_W       = 63;
    localparam int MOD_W       = 17;
    localparam int TABLE_DEPTH = 131072;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int PROD_W      = 2 * MOD_W;
    localparam int S_W         = MOD_W + 3;
    localparam int QBITS       = MOD_W;
    localparam int CNT_W       = $clog2(QBITS + 1);
    localparam int DCNT_W      = $clog2(ARG_W + 1);
    localparam int S_TDATA_W   = ((2 * ARG_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((MOD_W + 7) / 8) * 8;
    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(2);

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_DIGIT, ST_CMP,
        ST_RD_N, ST_RD_K, ST_RD_D, ST_RD_W,
        ST_EU_INIT, ST_EU_CHK, ST_EU_RUN, ST_EU_FIN,
        ST_MUL, ST_RED, ST_RED_WAIT,
        ST_FILL0, ST_FILL_CHK, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_INV_K, PH_INV_D, PH_ACC, PH_FILL
    } phase_t;

    typedef struct packed {
        logic                    done;
        logic [MOD_W-1:0]        rem;
        logic signed [S_W-1:0]   s;
    } rem_rsp_t;

    typedef struct packed {
        logic             done;
        logic [ARG_W-1:0] quo;
        logic [MOD_W-1:0] rem;
    } digit_rsp_t;

endpackage

// ----- hdl/lucas_binomial_mod_prime.sv -----
// Binomial C(n,k) mod p by Lucas's theorem, one query at a time. Per base-p
// digit of n it splits off the digit, then runs two extended-Euclid inverses
// and three reductions on the shared remainder unit.
// A modulus write fills the factorial memory, with s_tready low. Reset clears
// control, sets p to 2 and marks the table empty, so queries before the first
// modulus write return 0.
module lucas_binomial_mod_prime (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [luc_pkg::MOD_W-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [luc_pkg::S_TDATA_W-1:0] s_tdata,   // n_value, k_value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [luc_pkg::M_TDATA_W-1:0] m_tdata    // binomial_mod
);
    import luc_pkg::*;

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [MOD_W-1:0]      p_reg;
    logic                  ready_reg;
    logic [ARG_W-1:0]      n_reg, k_reg;
    logic [MOD_W-1:0]      r_reg, t_reg, nd_reg, kd_reg, fk_reg, fd_reg;
    logic [MOD_W-1:0]      e_r0_reg, e_r1_reg, inv_reg, fact_reg, fill_i_reg;
    logic signed [S_W-1:0] e_s0_reg, e_s1_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  out_valid_reg;
    logic [MOD_W-1:0]      out_data_reg;

    logic [MOD_W-1:0]      mem [TABLE_DEPTH];
    logic [MOD_W-1:0]      rdata_reg;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
    logic [MOD_W-1:0]      mem_wdata;

    logic                  rem_start, dig_start, out_load, cfg_ok;
    logic [PROD_W-1:0]     rem_dividend;
    logic [MOD_W-1:0]      rem_divisor, mul_a, mul_b, inv_calc;
    logic signed [S_W-1:0] p_s, norm_a, norm_b;
    rem_rsp_t              rem_rsp;
    digit_rsp_t            dig_n, dig_k;
    logic [ARG_W-1:0]      in_n, in_k;

    assign in_n   = s_tdata[ARG_W-1:0];
    assign in_k   = s_tdata[2*ARG_W-1:ARG_W];
    assign cfg_ok = cfg_wr_en && (cfg_wr_data >= MOD_W'(2));

    // Factorial memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Shared remainder unit: Euclid steps or reduction of a product.
    assign rem_dividend = (state_reg == ST_EU_CHK) ?
                          {{(PROD_W-MOD_W){1'b0}}, e_r0_reg} : prod_reg;
    assign rem_divisor  = (state_reg == ST_EU_CHK) ? e_r1_reg : p_reg;

    luc_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (rem_dividend),
        .divisor  (rem_divisor),
        .s_init   (e_s0_reg),
        .s_step   (e_s1_reg),
        .rsp      (rem_rsp)
    );

    // Digit extraction for n and k side by side.
    luc_digit u_dig_n (
        .aclk (aclk), .aresetn (aresetn), .start (dig_start),
        .dividend (n_reg), .divisor (p_reg), .rsp (dig_n)
    );
    luc_digit u_dig_k (
        .aclk (aclk), .aresetn (aresetn), .start (dig_start),
        .dividend (k_reg), .divisor (p_reg), .rsp (dig_k)
    );

    // Multiplier operands chosen by the current phase.
    always_comb begin
        unique case (phase_reg)
            PH_FILL: begin
                mul_a = fact_reg;
                mul_b = fill_i_reg;
            end
            PH_ACC: begin
                mul_a = r_reg;
                mul_b = t_reg;
            end
            default: begin
                mul_a = t_reg;
                mul_b = inv_reg;
            end
        endcase
    end

    // Bring the Euclid coefficient into 0..p-1.
    assign p_s = signed'({{(S_W-MOD_W){1'b0}}, p_reg});
    always_comb begin
        if (e_s0_reg >= p_s) begin
            norm_a = e_s0_reg - p_s;
        end else if (e_s0_reg <= -p_s) begin
            norm_a = e_s0_reg + p_s;
        end else begin
            norm_a = e_s0_reg;
        end
        norm_b   = (norm_a < 0) ? norm_a + p_s : norm_a;
        inv_calc = norm_b[MOD_W-1:0];
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_INV_K;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // Next state and control outputs.
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        rem_start  = 1'b0;
        dig_start  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = fill_i_reg[ADDR_W-1:0];
        mem_wdata  = rem_rsp.rem;
        mem_raddr  = nd_reg[ADDR_W-1:0];
        s_tready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = (!ready_reg || in_k > in_n) ? ST_DONE : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (n_reg == '0 || r_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    dig_start  = 1'b1;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (dig_n.done) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = (kd_reg > nd_reg) ? ST_DONE : ST_RD_N;
            end
            ST_RD_N: begin
                state_next = ST_RD_K;
            end
            ST_RD_K: begin
                mem_raddr  = kd_reg[ADDR_W-1:0];
                state_next = ST_RD_D;
            end
            ST_RD_D: begin
                mem_raddr  = ADDR_W'(nd_reg - kd_reg);
                state_next = ST_RD_W;
            end
            ST_RD_W: begin
                phase_next = PH_INV_K;
                state_next = ST_EU_INIT;
            end
            ST_EU_INIT: begin
                state_next = ST_EU_CHK;
            end
            ST_EU_CHK: begin
                if (e_r1_reg == '0) begin
                    state_next = ST_EU_FIN;
                end else begin
                    rem_start  = 1'b1;
                    state_next = ST_EU_RUN;
                end
            end
            ST_EU_RUN: begin
                if (rem_rsp.done) begin
                    state_next = ST_EU_CHK;
                end
            end
            ST_EU_FIN: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_RED;
            end
            ST_RED: begin
                rem_start  = 1'b1;
                state_next = ST_RED_WAIT;
            end
            ST_RED_WAIT: begin
                if (rem_rsp.done) begin
                    unique case (phase_reg)
                        PH_FILL: begin
                            mem_we     = 1'b1;
                            state_next = ST_FILL_CHK;
                        end
                        PH_INV_K: begin
                            phase_next = PH_INV_D;
                            state_next = ST_EU_INIT;
                        end
                        PH_INV_D: begin
                            phase_next = PH_ACC;
                            state_next = ST_MUL;
                        end
                        default: begin
                            state_next = ST_CHECK;
                        end
                    endcase
                end
            end
            ST_FILL0: begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = MOD_W'(1);
                state_next = ST_FILL_CHK;
            end
            ST_FILL_CHK: begin
                if (fill_i_reg == p_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    phase_next = PH_FILL;
                    state_next = ST_MUL;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // A modulus write restarts the table fill.
        if (cfg_ok) begin
            state_next = ST_FILL0;
        end
    end

    // Control registers: modulus, table status and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg         <= MOD_RESET;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_ok) begin
                p_reg     <= cfg_wr_data;
                ready_reg <= 1'b0;
            end else if (state_reg == ST_FILL_CHK && fill_i_reg == p_reg) begin
                ready_reg <= 1'b1;
            end
            out_valid_reg <= out_load || (out_valid_reg && !m_tready);
        end
    end

    // Datapath registers, updated by state.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= r_reg;
        end
        unique case (state_reg)
            ST_IDLE: begin
                n_reg <= in_n;
                k_reg <= in_k;
                r_reg <= (!ready_reg || in_k > in_n) ? '0 : MOD_W'(1);
            end
            ST_DIGIT: begin
                if (dig_n.done) begin
                    nd_reg <= dig_n.rem;
                    kd_reg <= dig_k.rem;
                    n_reg  <= dig_n.quo;
                    k_reg  <= dig_k.quo;
                end
            end
            ST_CMP: begin
                if (kd_reg > nd_reg) begin
                    r_reg <= '0;
                end
            end
            ST_RD_K: t_reg  <= rdata_reg;
            ST_RD_D: fk_reg <= rdata_reg;
            ST_RD_W: fd_reg <= rdata_reg;
            ST_EU_INIT: begin
                e_r0_reg <= (phase_reg == PH_INV_K) ? fk_reg : fd_reg;
                e_r1_reg <= p_reg;
                e_s0_reg <= S_W'(1);
                e_s1_reg <= '0;
            end
            ST_EU_RUN: begin
                if (rem_rsp.done) begin
                    e_r0_reg <= e_r1_reg;
                    e_r1_reg <= rem_rsp.rem;
                    e_s0_reg <= e_s1_reg;
                    e_s1_reg <= rem_rsp.s;
                end
            end
            ST_EU_FIN: inv_reg <= inv_calc;
            ST_MUL: prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
            ST_RED_WAIT: begin
                if (rem_rsp.done) begin
                    unique case (phase_reg)
                        PH_FILL: begin
                            fact_reg   <= rem_rsp.rem;
                            fill_i_reg <= fill_i_reg + MOD_W'(1);
                        end
                        PH_ACC:  r_reg <= rem_rsp.rem;
                        default: t_reg <= rem_rsp.rem;
                    endcase
                end
            end
            ST_FILL0: begin
                fact_reg   <= MOD_W'(1);
                fill_i_reg <= MOD_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-MOD_W){1'b0}}, out_data_reg};

endmodule

// ----- hdl/luc_rem.sv -----
// Shared remainder unit: restoring reduction, one quotient bit per cycle,
// that also forms s_init - q * s_step for the extended Euclid. Uses luc_pkg.
module luc_rem (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [luc_pkg::PROD_W-1:0]    dividend,
    input  logic [luc_pkg::MOD_W-1:0]     divisor,
    input  logic signed [luc_pkg::S_W-1:0] s_init,
    input  logic signed [luc_pkg::S_W-1:0] s_step,
    output luc_pkg::rem_rsp_t             rsp
);
    import luc_pkg::*;

    logic [PROD_W-1:0]     rem_reg;
    logic [MOD_W-1:0]      div_reg;
    logic signed [S_W-1:0] s_reg;
    logic signed [S_W-1:0] step_reg;
    logic [CNT_W-1:0]      bit_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic [PROD_W-1:0]     shifted_div;
    logic signed [S_W-1:0] shifted_s;
    logic                  fits;

    // Divisor and s step aligned to the current quotient bit.
    assign shifted_div = {{(PROD_W-MOD_W){1'b0}}, div_reg} << bit_reg;
    assign shifted_s   = step_reg <<< bit_reg;
    assign fits        = rem_reg >= shifted_div;

    // Control: step down through the quotient bits while running, then flag done.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                bit_reg <= CNT_W'(QBITS - 1);
            end else if (run_reg) begin
                if (bit_reg == '0) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    bit_reg <= bit_reg - CNT_W'(1);
                end
            end
        end
    end

    // Datapath: subtract the aligned divisor where it fits.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= dividend;
            div_reg  <= divisor;
            s_reg    <= s_init;
            step_reg <= s_step;
        end else if (run_reg && fits) begin
            rem_reg <= rem_reg - shifted_div;
            s_reg   <= s_reg - shifted_s;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg[MOD_W-1:0];
    assign rsp.s    = s_reg;

endmodule

// ----- hdl/luc_digit.sv -----
// Base-p digit unit: long division of a 63-bit argument by the modulus,
// one bit per cycle, giving quotient and digit. Uses luc_pkg.
module luc_digit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [luc_pkg::ARG_W-1:0] dividend,
    input  logic [luc_pkg::MOD_W-1:0] divisor,
    output luc_pkg::digit_rsp_t       rsp
);
    import luc_pkg::*;

    logic [ARG_W-1:0]  quo_reg;
    logic [MOD_W-1:0]  rem_reg;
    logic [MOD_W-1:0]  div_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              done_reg;
    logic [MOD_W:0]    trial;
    logic              ge;

    // Bring down the next dividend bit and compare with the divisor.
    assign trial = {rem_reg, quo_reg[ARG_W-1]};
    assign ge    = trial >= {1'b0, div_reg};

    // Control: count the dividend bits still to go.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= DCNT_W'(ARG_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the quotient bit in as the dividend shifts out.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (cnt_reg != '0) begin
            quo_reg <= {quo_reg[ARG_W-2:0], ge};
            rem_reg <= ge ? MOD_W'(trial - {1'b0, div_reg}) : trial[MOD_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- hdl/luc_checker.sv -----
// Port-level checker for the Lucas binomial block, bound to the top level.
// Uses luc_pkg for widths.
module luc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_wr_en,
    input logic [luc_pkg::MOD_W-1:0]     cfg_wr_data,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [luc_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [luc_pkg::M_TDATA_W-1:0] m_tdata
);
    import luc_pkg::*;

    logic [MOD_W-1:0] p_seen_reg;

    // Track the modulus in force as seen on the configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_seen_reg <= MOD_RESET;
        end else if (cfg_wr_en && cfg_wr_data >= MOD_W'(2)) begin
            p_seen_reg <= cfg_wr_data;
        end
    end

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Every result is a residue of the current modulus.
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[MOD_W-1:0] < p_seen_reg)
        else $error("result not below the modulus");

    // Padding bits stay zero.
    a_out_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:MOD_W] == '0)
        else $error("result padding not zero");

    // A valid modulus write starts the fill, so no query is taken next.
    a_fill_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && cfg_wr_data >= MOD_W'(2) |=> !s_tready)
        else $error("query accepted during table fill");

    // Nothing is offered straight after reset.
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind lucas_binomial_mod_prime luc_checker u_luc_checker (.*);

// ----- sim/lucas_checker.sv -----
// Checker for the Lucas binomial block: watches the modulus write, the query
// channel and the result channel, predicts C(n,k) mod p and compares results.
// Depends on luc_pkg for the widths of the ports.
module lucas_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [luc_pkg::MOD_W-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [luc_pkg::S_TDATA_W-1:0] s_tdata,   // n_value, k_value
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [luc_pkg::M_TDATA_W-1:0] m_tdata,   // binomial_mod
    output int                            pending,
    output int                            fail_count
);
    import luc_pkg::*;

    // Own copy of the modulus, the factorial table and the ready flag.
    int unsigned          modulus;
    bit                   table_filled;
    int unsigned          fact_tab [TABLE_DEPTH];
    bit [MOD_W-1:0]       binom_queue [$];

    // Modular inverse by extended Euclid; zero maps to zero.
    function automatic longint unsigned inverse_mod(longint unsigned v, longint unsigned p);
        longint r0, r1, s0, s1, q, t;
        r0 = v;
        r1 = p;
        s0 = 1;
        s1 = 0;
        while (r1 != 0) begin
            q  = r0 / r1;
            t  = r0 - q * r1;
            r0 = r1;
            r1 = t;
            t  = s0 - q * s1;
            s0 = s1;
            s1 = t;
        end
        s0 = s0 % longint'(p);
        if (s0 < 0) s0 += p;
        return s0;
    endfunction

    // Lucas product over the base-p digits of n and k.
    function automatic bit [MOD_W-1:0] lucas_binom(bit [ARG_W-1:0] n, bit [ARG_W-1:0] k);
        longint unsigned r, p, nd, kd, d;
        p = modulus;
        r = 1;
        if (!table_filled || k > n) return '0;
        while (n != 0 && r != 0) begin
            nd = n % p;
            kd = k % p;
            if (kd > nd) begin
                d = 0;
            end else begin
                d = fact_tab[nd];
                d = (d * inverse_mod(fact_tab[kd], p)) % p;
                d = (d * inverse_mod(fact_tab[nd - kd], p)) % p;
            end
            r = (r * d) % p;
            n = n / p;
            k = k / p;
        end
        return r[MOD_W-1:0];
    endfunction

    assign pending = binom_queue.size();

    // Track writes, predict on each query transaction and check each result.
    always @(posedge aclk) begin
        bit [MOD_W-1:0] want;
        if (!aresetn) begin
            modulus      = 2;
            table_filled = 0;
            fail_count   = 0;
            binom_queue.delete();
        end else begin
            if (cfg_wr_en && cfg_wr_data >= 2) begin
                modulus     = cfg_wr_data;
                fact_tab[0] = 1 % modulus;
                for (int i = 1; i < TABLE_DEPTH; i++)
                    fact_tab[i] = 32'((longint'(fact_tab[i-1]) * i) % modulus);
                table_filled = 1;
            end
            if (s_tvalid && s_tready)
                binom_queue.push_back(lucas_binom(s_tdata[ARG_W-1:0],
                                                  s_tdata[2*ARG_W-1:ARG_W]));
            if (m_tvalid && m_tready) begin
                if (binom_queue.size() == 0) begin
                    $display("%0t: unexpected result transaction, binomial_mod %0d",
                             $time, m_tdata[MOD_W-1:0]);
                    fail_count++;
                end else begin
                    want = binom_queue.pop_front();
                    if (m_tdata[MOD_W-1:0] !== want) begin
                        $display("%0t: binomial_mod expected %0d, got %0d",
                                 $time, want, m_tdata[MOD_W-1:0]);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ----- sim/tb.sv -----
// Testbench top for lucas_binomial_mod_prime: drives modulus writes and
// queries under several idling patterns; lucas_checker does the checking.
// Depends on luc_pkg, the block and sim/lucas_checker.sv.
module tb;
    import luc_pkg::*;

    localparam longint unsigned CYCLE_LIMIT = 30000000;
    localparam bit [ARG_W-1:0]  ARG_MAX     = '1;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 cfg_wr_en = 0;
    logic [MOD_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   pending;
    int                   fail_count;
    int                   idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
    longint unsigned      cycle_count = 0;

    always #1 aclk = ~aclk;

    lucas_binomial_mod_prime u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    lucas_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .pending(pending), .fail_count(fail_count)
    );

    // Receiver stalls at random in the phases that ask for it.
    always @(posedge aclk) begin
        if (idle_mode == 2)
            m_tready <= ($urandom_range(99) >= 48);
        else if (idle_mode == 3)
            m_tready <= ($urandom_range(99) >= 24);
        else
            m_tready <= 1'b1;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // One query transaction, with a random gap before it when the sender idles.
    task automatic send_query(bit [ARG_W-1:0] n, bit [ARG_W-1:0] k);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 48 : (idle_mode == 3) ? 24 : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, k, n};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Modulus write once every expected result has come back.
    task automatic write_modulus(bit [MOD_W-1:0] p);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= p;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Wide random query, or one from base-p digits, mostly k digits within n's.
    task automatic send_random(int unsigned p, bit wide);
        bit [ARG_W-1:0]  n, k;
        longint unsigned nd, kd;
        int              dmax, digits;
        if (wide || p < 2) begin
            n = ARG_W'({$urandom, $urandom});
            case ($urandom_range(3))
                0: k = ARG_W'({$urandom, $urandom});
                1: k = n - $urandom_range(3);
                default: k = n & ARG_W'({$urandom, $urandom});
            endcase
        end else begin
            dmax   = 62 / $clog2(p + 1);
            if (dmax > 8) dmax = 8;
            digits = $urandom_range(dmax, 1);
            n = 0;
            k = 0;
            for (int d = 0; d < digits; d++) begin
                nd = $urandom % p;
                kd = ($urandom_range(4) != 0) ? $urandom % (nd + 1) : $urandom % p;
                n  = ARG_W'(n * p + nd);
                k  = ARG_W'(k * p + kd);
            end
            if ($urandom_range(15) == 0) k = k + $urandom_range(5);
        end
        send_query(n, k);
    endtask

    // Phases: modulus or none, idling pattern, edge cases if p = 7, random queries.
    initial begin
        int unsigned plist [9];
        plist = '{0, 1, 3, 0, 2, 12, 7, 1009, 131071};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int ph = 0; ph < 9; ph++) begin
            if (ph > 0) write_modulus(plist[ph]);
            idle_mode = ph % 4;
            if (plist[ph] == 7) begin
                // Extremes, k above n, a digit of k above its digit of n.
                send_query(0, 0);
                send_query(ARG_MAX, 0);
                send_query(ARG_MAX, ARG_MAX);
                send_query(0, ARG_MAX);
                send_query(ARG_MAX, ARG_MAX - 1);
                send_query(6, 3);
                send_query(6, 6);
                send_query(5, 6);
                send_query(7, 1);
                send_query(48, 6);
                send_query(49, 7);
            end
            repeat (ph == 0 ? 30 : (ph == 1 || ph == 3) ? 15 : 110)
                send_random(ph < 2 ? 0 : plist[ph],
                            plist[ph] >= 1009 && $urandom_range(9) == 0);
        end
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
